// ----- rtl/ftg_pkg.sv -----
// Shared types, constants and the quarter-wave sine table of the trajectory generator.
package ftg_pkg;

  // Fixed field and register widths.
  localparam int PeriodW  = 16;
  localparam int PhaseW   = 32;
  localparam int IndexW   = 17;
  localparam int CfgIdxW  = 4;
  localparam int CfgDataW = 32;
  localparam int InDataW  = 8;
  localparam int PosW     = 24;
  localparam int OutUserW = 2;

  // Defaults for the top-level parameters.
  localparam int DefHarmonicCount = 5;
  localparam int DefStepsPerRev   = 51200;

  // The coefficient set covers at most five harmonics.
  localparam int MaxHarm = 5;

  // Phase resolution used for the sine lookup.
  localparam int SinBits      = 10;
  localparam int QuarterSteps = 2 ** (SinBits - 2);
  localparam int QuarterIdxW  = SinBits - 1;

  // Arithmetic widths.
  localparam int LutW   = 31;  // 0 .. 2^30
  localparam int SinW   = 32;  // signed Q30
  localparam int CoefW  = 28;  // signed Q24
  localparam int ProdW  = CoefW + SinW;
  localparam int DiffW  = ProdW + 1;
  localparam int AccW   = 64;
  localparam int TurnsW = 40;
  localparam int FracW  = 30;
  localparam int TurnShift = 24;

  // Register reset values.
  localparam logic [PeriodW-1:0] PeriodReset   = 16'd5000;
  localparam logic [PhaseW-1:0]  PhaseIncReset = 32'd858993;

  typedef enum logic [CfgIdxW-1:0] {
    CfgPeriod   = 4'd0,
    CfgPhaseInc = 4'd1
  } cfg_reg_e;

  // Per-tick status that travels alongside the data through the pipeline.
  typedef struct packed {
    logic setpoint;
    logic finished;
  } tick_flags_t;

  typedef logic signed [CoefW-1:0] coef_arr_t [MaxHarm];

  // Turn coefficients in Q24, already scaled to output turns.
  localparam coef_arr_t CoefSin = '{
    -28'sd26203085, 28'sd84353042, 28'sd78767, -28'sd15337, -28'sd28535590
  };
  localparam coef_arr_t CoefCos = '{
    -28'sd4595194, -28'sd36270063, -28'sd293684, -28'sd239, 28'sd6092897
  };
  localparam logic signed [CoefW-1:0] CoefOff = -28'sd35066284;

  typedef logic [LutW-1:0] sin_lut_t [QuarterSteps + 1];

  // Drops FracW fraction bits, rounding toward zero like a signed division.
  function automatic longint drop_frac(longint v);
    return (v < 0) ? -((-v) >>> FracW) : (v >>> FracW);
  endfunction

  // Evaluates the odd sine polynomial on every quarter-wave step at elaboration.
  function automatic sin_lut_t build_sin_lut();
    sin_lut_t lut;
    longint   x;
    longint   x2;
    longint   r;
    longint   s;
    longint   one;
    one = 64'sd1 <<< FracW;
    for (int i = 0; i <= QuarterSteps; i++) begin
      x  = longint'(i) <<< (FracW - (SinBits - 2));
      x2 = drop_frac(x * x);
      r  = 64'sd172273;
      r  = -64'sd5026994 + drop_frac(r * x2);
      r  = 64'sd85569306 + drop_frac(r * x2);
      r  = -64'sd693598674 + drop_frac(r * x2);
      r  = 64'sd1686629713 + drop_frac(r * x2);
      s  = drop_frac(r * x);
      if (s < 0) s = 0;
      if (s > one) s = one;
      lut[i] = LutW'(s);
    end
    return lut;
  endfunction

  localparam sin_lut_t SinLut = build_sin_lut();

endpackage

// ----- rtl/ftg_seq.sv -----
// Tick sequencer: configuration registers, run state, index, phase accumulators, first stage.
module ftg_seq #(
  parameter int HarmonicCount = ftg_pkg::DefHarmonicCount
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [ftg_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [ftg_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         start_req_i,
  input  logic                         rewind_i,
  output logic                         valid_o,
  input  logic                         ready_i,
  output ftg_pkg::tick_flags_t         flags_o,
  output logic [ftg_pkg::SinBits-1:0]  phase_o [HarmonicCount]
);

  logic [ftg_pkg::PeriodW-1:0] period_q;
  logic [ftg_pkg::PhaseW-1:0]  phase_inc_q;
  logic [ftg_pkg::IndexW-1:0]  index_q, index_d, index_eff;
  logic                        run_q, run_d, run_eff;
  logic [ftg_pkg::PhaseW-1:0]  phase_q [HarmonicCount];
  logic [ftg_pkg::PhaseW-1:0]  phase_d [HarmonicCount];
  logic [ftg_pkg::PhaseW-1:0]  phase_eff [HarmonicCount];
  logic                        go;
  logic                        accept;
  logic                        out_v_q;
  ftg_pkg::tick_flags_t        flags_q;
  logic [ftg_pkg::SinBits-1:0] top_q [HarmonicCount];

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !out_v_q || ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign valid_o     = out_v_q;
  assign flags_o     = flags_q;
  assign phase_o     = top_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q    <= ftg_pkg::PeriodReset;
      phase_inc_q <= ftg_pkg::PhaseIncReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        ftg_pkg::CfgPeriod:   period_q    <= cfg_data_i[ftg_pkg::PeriodW-1:0];
        ftg_pkg::CfgPhaseInc: phase_inc_q <= cfg_data_i[ftg_pkg::PhaseW-1:0];
        default: ;
      endcase
    end
  end

  // Rewind and start act before the range check of the same tick.
  always_comb begin
    index_eff = rewind_i ? '0 : index_q;
    run_eff   = run_q || start_req_i;
    go        = run_eff && (index_eff <= ftg_pkg::IndexW'(period_q));
    index_d   = index_q;
    run_d     = run_q;
    for (int k = 0; k < HarmonicCount; k++) begin
      phase_eff[k] = rewind_i ? '0 : phase_q[k];
      phase_d[k]   = phase_q[k];
    end
    if (accept) begin
      run_d = go;
      if (go) begin
        index_d = index_eff + ftg_pkg::IndexW'(1);
        for (int k = 0; k < HarmonicCount; k++) begin
          phase_d[k] = phase_eff[k]
                     + ftg_pkg::PhaseW'(phase_inc_q * ftg_pkg::PhaseW'(k + 1));
        end
      end else begin
        index_d = '0;
        for (int k = 0; k < HarmonicCount; k++) begin
          phase_d[k] = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      index_q <= '0;
      run_q   <= 1'b0;
      out_v_q <= 1'b0;
      for (int k = 0; k < HarmonicCount; k++) begin
        phase_q[k] <= '0;
      end
    end else begin
      index_q <= index_d;
      run_q   <= run_d;
      phase_q <= phase_d;
      if (in_ready_o) begin
        out_v_q <= in_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      flags_q.setpoint <= go;
      flags_q.finished <= !go && run_eff;
      for (int k = 0; k < HarmonicCount; k++) begin
        top_q[k] <= phase_eff[k][ftg_pkg::PhaseW-1 -: ftg_pkg::SinBits];
      end
    end
  end

endmodule

// ----- rtl/ftg_harm.sv -----
// Per-harmonic lanes: sine and cosine lookup, coefficient products and their difference.
module ftg_harm #(
  parameter int HarmonicCount = ftg_pkg::DefHarmonicCount
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  output logic                                ready_o,
  input  ftg_pkg::tick_flags_t                flags_i,
  input  logic [ftg_pkg::SinBits-1:0]         phase_i [HarmonicCount],
  output logic                                valid_o,
  input  logic                                ready_i,
  output ftg_pkg::tick_flags_t                flags_o,
  output logic signed [ftg_pkg::DiffW-1:0]    diff_o [HarmonicCount]
);

  localparam int Stages = 3;

  logic [Stages-1:0]    v_q;
  logic [Stages-1:0]    ld;
  ftg_pkg::tick_flags_t flags_q [Stages];

  logic signed [ftg_pkg::SinW-1:0]  sin_q  [HarmonicCount];
  logic signed [ftg_pkg::SinW-1:0]  cos_q  [HarmonicCount];
  logic signed [ftg_pkg::ProdW-1:0] prod_s_q [HarmonicCount];
  logic signed [ftg_pkg::ProdW-1:0] prod_c_q [HarmonicCount];
  logic signed [ftg_pkg::DiffW-1:0] diff_q [HarmonicCount];

  // Folds the phase onto a quarter wave and takes the sign from the upper quadrants.
  function automatic logic signed [ftg_pkg::SinW-1:0] sin_lookup(
    input logic [ftg_pkg::SinBits-1:0] p
  );
    logic [ftg_pkg::QuarterIdxW-1:0] idx;
    logic [ftg_pkg::QuarterIdxW-1:0] frac;
    logic [ftg_pkg::LutW-1:0]        mag;
    logic signed [ftg_pkg::SinW-1:0] val;
    frac = {1'b0, p[ftg_pkg::SinBits-3:0]};
    idx  = p[ftg_pkg::SinBits-2]
         ? ftg_pkg::QuarterIdxW'(ftg_pkg::QuarterSteps) - frac : frac;
    mag  = ftg_pkg::SinLut[idx];
    val  = $signed({1'b0, mag});
    return p[ftg_pkg::SinBits-1] ? -val : val;
  endfunction

  always_comb begin
    ld[2] = !v_q[2] || ready_i;
    ld[1] = !v_q[1] || ld[2];
    ld[0] = !v_q[0] || ld[1];
  end

  assign ready_o = ld[0];
  assign valid_o = v_q[Stages-1];
  assign flags_o = flags_q[Stages-1];
  assign diff_o  = diff_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (ld[0]) v_q[0] <= valid_i;
      if (ld[1]) v_q[1] <= v_q[0];
      if (ld[2]) v_q[2] <= v_q[1];
    end
  end

  // The cosine is the sine a quarter turn ahead.
  always_ff @(posedge clk_i) begin
    if (ld[0]) begin
      flags_q[0] <= flags_i;
      for (int k = 0; k < HarmonicCount; k++) begin
        sin_q[k] <= sin_lookup(phase_i[k]);
        cos_q[k] <= sin_lookup(phase_i[k] + ftg_pkg::SinBits'(ftg_pkg::QuarterSteps));
      end
    end
    if (ld[1]) begin
      flags_q[1] <= flags_q[0];
      for (int k = 0; k < HarmonicCount; k++) begin
        prod_s_q[k] <= ftg_pkg::ProdW'(ftg_pkg::CoefSin[k]) * ftg_pkg::ProdW'(sin_q[k]);
        prod_c_q[k] <= ftg_pkg::ProdW'(ftg_pkg::CoefCos[k]) * ftg_pkg::ProdW'(cos_q[k]);
      end
    end
    if (ld[2]) begin
      flags_q[2] <= flags_q[1];
      for (int k = 0; k < HarmonicCount; k++) begin
        diff_q[k] <= ftg_pkg::DiffW'(prod_s_q[k]) - ftg_pkg::DiffW'(prod_c_q[k]);
      end
    end
  end

endmodule

// ----- rtl/ftg_sum.sv -----
// Sums the harmonic terms with the offset and scales turns to saturated microsteps.
module ftg_sum #(
  parameter int HarmonicCount = ftg_pkg::DefHarmonicCount,
  parameter int StepsPerRev   = ftg_pkg::DefStepsPerRev
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             valid_i,
  output logic                             ready_o,
  input  ftg_pkg::tick_flags_t             flags_i,
  input  logic signed [ftg_pkg::DiffW-1:0] diff_i [HarmonicCount],
  output logic                             valid_o,
  input  logic                             ready_i,
  output ftg_pkg::tick_flags_t             flags_o,
  output logic signed [ftg_pkg::PosW-1:0]  pos_o
);

  localparam int Stages = 5;
  localparam int Terms  = ftg_pkg::MaxHarm + 1;
  localparam int AccW   = ftg_pkg::AccW;
  localparam int StepsW = $clog2(StepsPerRev + 1) + 1;

  localparam logic signed [StepsW-1:0] StepsS = StepsW'(StepsPerRev);
  localparam logic signed [AccW-1:0] PosMax = AccW'((64'sd1 <<< (ftg_pkg::PosW - 1)) - 1);
  localparam logic signed [AccW-1:0] PosMin = -(AccW'(64'sd1 <<< (ftg_pkg::PosW - 1)));
  localparam logic signed [AccW-1:0] TurnBias = AccW'((64'sd1 <<< ftg_pkg::TurnShift) - 1);
  localparam logic signed [AccW-1:0] FracBias = AccW'((64'sd1 <<< ftg_pkg::FracW) - 1);
  localparam logic signed [AccW-1:0] NoBias   = AccW'(0);

  logic [Stages-1:0]    v_q;
  logic [Stages-1:0]    ld;
  ftg_pkg::tick_flags_t flags_q [Stages];

  logic signed [AccW-1:0]           term [Terms];
  logic signed [AccW-1:0]           part_q [3];
  logic signed [AccW-1:0]           total_q;
  logic signed [ftg_pkg::TurnsW-1:0] turns_q;
  logic signed [AccW-1:0]           scaled_q;
  logic signed [ftg_pkg::PosW-1:0]  pos_q;
  logic signed [AccW-1:0]           turns_full;
  logic signed [AccW-1:0]           steps_full;
  logic signed [AccW-1:0]           pos_full;
  logic signed [ftg_pkg::PosW-1:0]  pos_sat;

  // Lanes above the harmonic count contribute nothing; the last term is the offset.
  for (genvar k = 0; k < ftg_pkg::MaxHarm; k++) begin : g_term
    if (k < HarmonicCount) begin : g_used
      assign term[k] = AccW'(diff_i[k]);
    end else begin : g_unused
      assign term[k] = '0;
    end
  end
  assign term[Terms-1] = AccW'(ftg_pkg::CoefOff) <<< ftg_pkg::FracW;

  // Both divisions round toward zero: negative values get a bias before the shift.
  always_comb begin
    turns_full = (total_q + (total_q[AccW-1] ? TurnBias : NoBias)) >>> ftg_pkg::TurnShift;
    steps_full = (scaled_q + (scaled_q[AccW-1] ? FracBias : NoBias)) >>> ftg_pkg::FracW;
    pos_full   = steps_full;
    if (pos_full > PosMax) begin
      pos_sat = ftg_pkg::PosW'(PosMax);
    end else if (pos_full < PosMin) begin
      pos_sat = ftg_pkg::PosW'(PosMin);
    end else begin
      pos_sat = ftg_pkg::PosW'(pos_full);
    end
  end

  always_comb begin
    ld[4] = !v_q[4] || ready_i;
    ld[3] = !v_q[3] || ld[4];
    ld[2] = !v_q[2] || ld[3];
    ld[1] = !v_q[1] || ld[2];
    ld[0] = !v_q[0] || ld[1];
  end

  assign ready_o = ld[0];
  assign valid_o = v_q[Stages-1];
  assign flags_o = flags_q[Stages-1];
  assign pos_o   = pos_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (ld[0]) v_q[0] <= valid_i;
      if (ld[1]) v_q[1] <= v_q[0];
      if (ld[2]) v_q[2] <= v_q[1];
      if (ld[3]) v_q[3] <= v_q[2];
      if (ld[4]) v_q[4] <= v_q[3];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[0]) begin
      flags_q[0] <= flags_i;
      part_q[0]  <= term[0] + term[1];
      part_q[1]  <= term[2] + term[3];
      part_q[2]  <= term[4] + term[5];
    end
    if (ld[1]) begin
      flags_q[1] <= flags_q[0];
      total_q    <= part_q[0] + part_q[1] + part_q[2];
    end
    if (ld[2]) begin
      flags_q[2] <= flags_q[1];
      turns_q    <= ftg_pkg::TurnsW'(turns_full);
    end
    if (ld[3]) begin
      flags_q[3] <= flags_q[2];
      scaled_q   <= AccW'(turns_q) * AccW'(StepsS);
    end
    if (ld[4]) begin
      flags_q[4] <= flags_q[3];
      pos_q      <= flags_q[3].setpoint ? pos_sat : '0;
    end
  end

endmodule

// ----- rtl/fourier_trajectory_generator_top.sv -----
// Top level of the five-harmonic Fourier trajectory generator.
//
// Each transfer on the slave stream is one control tick: tdata bit 0 requests a run
// (start), bit 1 rewinds the sample index and all harmonic phases to zero first.
// Each tick yields exactly one transfer on the master stream: tdata carries the
// position setpoint in microsteps (signed, truncated toward zero, saturated to 24
// bits), tuser bit 0 marks a produced setpoint and tuser bit 1 marks the tick on
// which a run ended. Without a setpoint the position reads zero.
// The configuration channel writes the period in ticks (index 0) and the base phase
// step per tick (index 1); it is always ready, and writes to other indexes are dropped.
// The run state and phase accumulators update in the cycle of the input transfer; the
// setpoint arithmetic follows in a nine-stage pipeline. One tick is taken per cycle while
// the master side does not stall. The depth is set by the phase register, the sine lookup,
// the two multiplier stages, the difference, the adder tree, rounding and saturation.
// Reset clears the run flag, index, phases and the pipeline valid flags and loads the
// register defaults. When the receiver stalls, results collect in empty pipeline
// stages; input is held off only once every stage is full.
module fourier_trajectory_generator_top #(
  parameter int HarmonicCount = ftg_pkg::DefHarmonicCount,
  parameter int StepsPerRev   = ftg_pkg::DefStepsPerRev
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [ftg_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [ftg_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [ftg_pkg::InDataW-1:0]   s_axis_tdata,   // [0] start_req, [1] rewind
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [ftg_pkg::PosW-1:0]      m_axis_tdata,   // [23:0] position_steps
  output logic [ftg_pkg::OutUserW-1:0]  m_axis_tuser    // [0] setpoint_valid, [1] finished
);

  logic                             seq_valid, seq_ready;
  ftg_pkg::tick_flags_t             seq_flags;
  logic [ftg_pkg::SinBits-1:0]      seq_phase [HarmonicCount];
  logic                             harm_valid, harm_ready;
  ftg_pkg::tick_flags_t             harm_flags;
  logic signed [ftg_pkg::DiffW-1:0] harm_diff [HarmonicCount];
  ftg_pkg::tick_flags_t             out_flags;
  logic signed [ftg_pkg::PosW-1:0]  out_pos;

  ftg_seq #(
    .HarmonicCount(HarmonicCount)
  ) u_seq (
    .clk_i,
    .rst_ni,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i,
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .start_req_i(s_axis_tdata[0]),
    .rewind_i   (s_axis_tdata[1]),
    .valid_o    (seq_valid),
    .ready_i    (seq_ready),
    .flags_o    (seq_flags),
    .phase_o    (seq_phase)
  );

  ftg_harm #(
    .HarmonicCount(HarmonicCount)
  ) u_harm (
    .clk_i,
    .rst_ni,
    .valid_i(seq_valid),
    .ready_o(seq_ready),
    .flags_i(seq_flags),
    .phase_i(seq_phase),
    .valid_o(harm_valid),
    .ready_i(harm_ready),
    .flags_o(harm_flags),
    .diff_o (harm_diff)
  );

  ftg_sum #(
    .HarmonicCount(HarmonicCount),
    .StepsPerRev  (StepsPerRev)
  ) u_sum (
    .clk_i,
    .rst_ni,
    .valid_i(harm_valid),
    .ready_o(harm_ready),
    .flags_i(harm_flags),
    .diff_i (harm_diff),
    .valid_o(m_axis_tvalid),
    .ready_i(m_axis_tready),
    .flags_o(out_flags),
    .pos_o  (out_pos)
  );

  assign m_axis_tdata = out_pos;
  assign m_axis_tuser = {out_flags.finished, out_flags.setpoint};

endmodule

// ----- rtl/ftg_checker.sv -----
// Port-level checks of the trajectory generator, bound to its top level.
module ftg_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tready,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [ftg_pkg::PosW-1:0]     m_axis_tdata,
  input logic [ftg_pkg::OutUserW-1:0] m_axis_tuser
);

  // A result that is not taken stays put.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // Input is refused only when the pipeline is full behind a stalled result.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input refused without output backpressure");

  // A tick either produces a setpoint or ends a run, never both.
  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
    else $error("setpoint and finish on the same tick");

  // Ticks without a setpoint report a zero position.
  a_zero_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == '0)
    else $error("nonzero position without setpoint");

endmodule

bind fourier_trajectory_generator_top ftg_checker u_ftg_checker (.*);

// ----- verif/fourier_trajectory_generator_top_tb.sv -----
// Self-checking stream testbench for the five-harmonic Fourier trajectory generator.
module fourier_trajectory_generator_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ftg_pkg::*;

  localparam int DrainCycles   = 16;
  localparam int HoldCycles    = 300;
  localparam int RandPhases    = 8;
  localparam int PhaseItems    = 115;
  localparam int PressurePhase = 3;

  // Register indexes that decode to nothing.
  localparam logic [CfgIdxW-1:0] CfgUnusedLo = CfgIdxW'(CfgPhaseInc + 1);
  localparam logic [CfgIdxW-1:0] CfgUnusedHi = '1;

  typedef struct packed {
    logic             setpoint;
    logic             finished;
    logic [PosW-1:0]  position;
  } tick_result_t;

  // Tracks the run state of the generator and holds the results still owed by it.
  class setpoint_board;
    logic [PeriodW-1:0] period;
    logic [PhaseW-1:0]  phase_step;
    logic [IndexW-1:0]  index;
    logic               running;
    logic [PhaseW-1:0]  phase [MaxHarm];
    tick_result_t       expected_q [$];
    int                 errors;

    function new();
      period     = PeriodReset;
      phase_step = PhaseIncReset;
      running    = 1'b0;
      errors     = 0;
      restart();
    endfunction

    function void restart();
      index = '0;
      foreach (phase[k]) phase[k] = '0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        CfgPeriod:   period = data[PeriodW-1:0];
        CfgPhaseInc: phase_step = data[PhaseW-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Sine of a phase in turns, as signed Q30, from the quarter-wave odd polynomial.
    function longint wave_sine(logic [PhaseW-1:0] ph);
      logic [PhaseW-1:0] p;
      longint one;
      longint x;
      longint x2;
      longint r;
      longint s;
      one = longint'(1) <<< FracW;
      p   = (ph >> (PhaseW - SinBits)) << (PhaseW - SinBits);
      x   = longint'({2'b00, p[FracW-1:0]});
      if (p[FracW]) x = one - x;
      x2 = (x * x) / one;
      r  = 172273;
      r  = -5026994 + (r * x2) / one;
      r  = 85569306 + (r * x2) / one;
      r  = -693598674 + (r * x2) / one;
      r  = 1686629713 + (r * x2) / one;
      s  = (r * x) / one;
      if (s < 0) s = 0;
      if (s > one) s = one;
      return p[PhaseW-1] ? -s : s;
    endfunction

    function void note_tick(logic start_req, logic rewind);
      tick_result_t res;
      longint one;
      longint acc;
      longint turns;
      longint pos;
      res = '0;
      one = longint'(1) <<< FracW;
      if (rewind) restart();
      if (start_req) running = 1'b1;
      if (running && ({1'b0, period} >= index)) begin
        acc = longint'(CoefOff) * one;
        for (int k = 0; k < DefHarmonicCount; k++) begin
          acc += longint'(CoefSin[k]) * wave_sine(phase[k])
               - longint'(CoefCos[k]) * wave_sine(phase[k] + 32'h4000_0000);
        end
        turns = acc / (longint'(1) <<< TurnShift);
        pos   = (turns * longint'(DefStepsPerRev)) / one;
        if (pos > (longint'(1) <<< (PosW - 1)) - 1) pos = (longint'(1) <<< (PosW - 1)) - 1;
        if (pos < -(longint'(1) <<< (PosW - 1))) pos = -(longint'(1) <<< (PosW - 1));
        res.setpoint = 1'b1;
        res.position = pos[PosW-1:0];
        index = index + 1'b1;
        for (int k = 0; k < DefHarmonicCount; k++) begin
          phase[k] = phase[k] + PhaseW'(k + 1) * phase_step;
        end
      end else begin
        res.finished = running;
        running = 1'b0;
        restart();
      end
      expected_q.push_back(res);
    endfunction

    function void check_result(logic [PosW-1:0] position, logic [OutUserW-1:0] user);
      tick_result_t exp_res;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result, position %0d flags %b", $time,
                 $signed(position), user);
        errors++;
        return;
      end
      exp_res = expected_q.pop_front();
      if (user[0] !== exp_res.setpoint) begin
        $display("%0t: setpoint_valid expected %b actual %b", $time, exp_res.setpoint, user[0]);
        errors++;
      end
      if (user[1] !== exp_res.finished) begin
        $display("%0t: finished expected %b actual %b", $time, exp_res.finished, user[1]);
        errors++;
      end
      if (position !== exp_res.position) begin
        $display("%0t: position_steps expected %0d actual %0d", $time,
                 $signed(exp_res.position), $signed(position));
        errors++;
      end
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_valid_i   = 1'b0;
  logic                 cfg_ready_o;
  logic [CfgIdxW-1:0]   cfg_index_i   = '0;
  logic [CfgDataW-1:0]  cfg_data_i    = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [InDataW-1:0]   s_axis_tdata  = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b1;
  logic [PosW-1:0]      m_axis_tdata;
  logic [OutUserW-1:0]  m_axis_tuser;

  setpoint_board board;
  bit send_gaps = 1'b1;
  bit recv_gaps = 1'b1;
  bit hold_req  = 1'b0;

  fourier_trajectory_generator_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("** fourier_trajectory_generator_top: FAILED **");
    $finish;
  end

  // Both transfers of an edge are recorded here, the input one first.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) board.note_tick(s_axis_tdata[0], s_axis_tdata[1]);
      if (m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tdata, m_axis_tuser);
    end
  end

  // Receiver: short random stalls, plus one long hold-off on request.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_req = 1'b0;
        m_axis_tready <= 1'b1;
      end else if (recv_gaps && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic send_tick(input logic start_req, input logic rewind);
    if (send_gaps && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(InDataW - 2){1'b0}}, rewind, start_req};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // The first edge lets the monitor record the last input transfer before counting.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (board.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    drain_results();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    board.write_reg(idx, data);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    board = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Default registers: idle tick, a short run, rewinds while running.
    send_tick(1'b0, 1'b0);
    repeat (3) send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b1, 1'b1);
    send_tick(1'b0, 1'b0);

    // Zero period: one setpoint per run, and a held start restarts after finishing.
    write_register(CfgPeriod, '0);
    repeat (4) send_tick(1'b1, 1'b0);
    repeat (2) send_tick(1'b0, 1'b0);

    // Zero phase step gives a constant setpoint.
    write_register(CfgPeriod, 32'd1);
    write_register(CfgPhaseInc, '0);
    repeat (3) send_tick(1'b1, 1'b0);
    send_tick(1'b1, 1'b1);

    write_register(CfgPeriod, 32'(16'hFFFF));
    write_register(CfgPhaseInc, '1);
    send_tick(1'b1, 1'b1);
    repeat (4) send_tick(1'b1, 1'b0);

    // Writes to undecoded indexes must leave both registers alone.
    write_register(CfgUnusedLo, $urandom());
    write_register(CfgUnusedHi, $urandom());
    repeat (2) send_tick(1'b1, 1'b0);

    for (int ph = 0; ph < RandPhases; ph++) begin
      logic [PeriodW-1:0] per;
      logic [PhaseW-1:0]  step;
      int                 sent;
      int                 len;
      case (ph)
        1: begin
          per  = '0;
          step = $urandom();
        end
        2: begin
          per  = '1;
          step = '1;
        end
        5: begin
          per  = PeriodW'($urandom_range(1, 12));
          step = 32'd1;
        end
        default: begin
          per  = PeriodW'($urandom_range(1, 48));
          step = $urandom_range(0, 1) ? $urandom() : 32'hFFFF_FFFF / per;
        end
      endcase
      write_register(CfgPeriod, CfgDataW'(per));
      write_register(CfgPhaseInc, step);
      send_gaps = (ph != RandPhases - 1);
      recv_gaps = (ph != RandPhases - 1);
      if (ph == PressurePhase) hold_req = 1'b1;
      sent = 0;
      while (sent < PhaseItems) begin
        if ($urandom_range(0, 4) == 0) begin
          send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
          sent++;
        end else begin
          // A run: start held for a while with the odd rewind, then released.
          len = $urandom_range(1, 40);
          repeat (len) begin
            send_tick(1'b1, $urandom_range(0, 29) == 0);
            sent++;
          end
          repeat ($urandom_range(1, 3)) begin
            send_tick(1'b0, 1'b0);
            sent++;
          end
        end
      end
    end

    drain_results();
    if (board.errors == 0) begin
      $display("** fourier_trajectory_generator_top: PASSED **");
    end else begin
      $display("** fourier_trajectory_generator_top: FAILED **");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/ftg_pkg.sv
rtl/ftg_seq.sv
rtl/ftg_harm.sv
rtl/ftg_sum.sv
rtl/fourier_trajectory_generator_top.sv
rtl/ftg_checker.sv
verif/fourier_trajectory_generator_top_tb.sv
